### design/c3x3zp_pkg.sv
// Shared types and constants of the 3x3 zero-padded convolution filter.
package c3x3zp_pkg;

   // Default parameter values
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_PIXEL_BITS = 16;
   localparam int DEF_COEF_BITS  = 16;

   // Fixed field widths
   localparam int DIM_W        = 11;    // image_width / image_height registers
   localparam int HEIGHT_LIMIT = 1024;  // largest usable image height
   localparam int KROW_W       = 48;    // one kernel row register
   localparam int FILT_W       = 36;    // Q8.28 result
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 48;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_KERNEL_TOP    = 3'd2,
      CSR_KERNEL_MID    = 3'd3,
      CSR_KERNEL_BOTTOM = 3'd4
   } c3x3zp_csr_type;

   // Input item kinds
   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_FLUSH = 1'b1
   } c3x3zp_cmd_type;

   // Per-item control carried from the line memory read to the multipliers
   typedef struct packed {
      logic emit;      // item completes a neighborhood
      logic eof;       // that neighborhood belongs to the frame's last pixel
      logic top_ok;    // upper kernel row inside the image
      logic bot_ok;    // lower kernel row inside the image
      logic left_ok;   // left kernel column inside the image
      logic right_ok;  // right kernel column inside the image
   } c3x3zp_tag_type;

endpackage

### design/c3x3zp_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
module c3x3zp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when both ports hit the same entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/conv3x3_zero_pad_filter_core.sv
// 3x3 convolution with zero padding over a raster-order grayscale pixel stream.
//
// Input channel req_*: one item per transfer, req_cmd selects pixel or flush.
// Flush items sent before the frame's last pixel are taken and dropped; after
// it, image_width + 1 items (flush or pixel) drain the remaining results, the
// last of which carries rsp_end_of_frame. Result channel rsp_*: one Q8.28 sum
// per transfer, held steady while rsp_stall is high.
// Throughput: one item per clock while req_stall is low. Both line buffers
// share one RAM entry per column, read when an item is taken and written back
// when it leaves stage 1; a bypass register covers a one-pixel-wide image,
// where consecutive items hit the same entry. A completed neighborhood moves
// from stage 1 through the product and row-sum registers to the output register.
// While rsp_stall is high the pipeline keeps filling its empty stages and
// keeps taking items that produce no result; req_stall rises only when a
// result-producing item cannot move into a full multiplier stage.
// Reset: width 1, height 1, zero kernel, frame counters cleared, pipeline
// empty. The line RAM is not cleared: taps outside the image are masked and
// every tap inside it was written earlier in the same frame.
// csr_*: always ready; writing width or height restarts the frame.
module conv3x3_zero_pad_filter_core #(
   parameter int MAX_WIDTH  = c3x3zp_pkg::DEF_MAX_WIDTH,
   parameter int PIXEL_BITS = c3x3zp_pkg::DEF_PIXEL_BITS,
   parameter int COEF_BITS  = c3x3zp_pkg::DEF_COEF_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_cmd,
   input  logic [PIXEL_BITS-1:0]                  req_pixel,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [c3x3zp_pkg::FILT_W-1:0]   rsp_filtered,
   output logic                                   rsp_end_of_frame,
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [c3x3zp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [c3x3zp_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int DIM_W  = c3x3zp_pkg::DIM_W;
   localparam int KROW_W = c3x3zp_pkg::KROW_W;
   localparam int FILT_W = c3x3zp_pkg::FILT_W;
   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
   localparam int EW     = (CNT_W > DIM_W) ? CNT_W : DIM_W;
   localparam int LINE_W = 2 * PIXEL_BITS;
   localparam int PROD_W = PIXEL_BITS + COEF_BITS + 1;
   localparam int ROW_W  = PROD_W + 2;
   localparam int ACC_W  = (ROW_W + 2 > FILT_W) ? ROW_W + 2 : FILT_W;
   localparam int KX_W   = (3 * COEF_BITS > KROW_W) ? 3 * COEF_BITS : KROW_W;

   // configuration registers
   logic [DIM_W-1:0]  width_ff;
   logic [DIM_W-1:0]  height_ff;
   logic [KROW_W-1:0] kernel_ff [3];

   // frame position of the next item
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0]  row_ff, row_in;

   // stage 1: line RAM read data valid
   logic                       s1_valid_ff, s1_valid_in;
   c3x3zp_pkg::c3x3zp_tag_type s1_tag_ff, tag_in;
   logic [ADDR_W-1:0]          s1_addr_ff;
   logic [PIXEL_BITS-1:0]      s1_pix_ff, pix_in;

   // same-entry bypass for back-to-back items
   logic              fwd_hit_ff, fwd_hit_in;
   logic [LINE_W-1:0] fwd_line_ff, fwd_line_in;

   // 3x3 window, [row][column], column 2 newest
   logic [PIXEL_BITS-1:0] win_ff [3][3];
   logic [PIXEL_BITS-1:0] win_in [3][3];

   // stage 2: products
   logic                     s2_valid_ff, s2_valid_in, s2_eof_ff;
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [PROD_W-1:0] prod_in [3][3];

   // stage 3: row sums
   logic                    s3_valid_ff, s3_valid_in, s3_eof_ff;
   logic signed [ROW_W-1:0] rowsum_ff [3];
   logic signed [ROW_W-1:0] rowsum_in [3];

   // output register
   logic                     rsp_valid_ff, rsp_valid_in, rsp_eof_ff;
   logic signed [FILT_W-1:0] rsp_filtered_ff;
   logic signed [ACC_W-1:0]  acc_in;

   // misc combinational
   logic                  csr_we, geo_write;
   logic [EW-1:0]         width_ext, eff_w, col_ext;
   logic [DIM_W-1:0]      eff_h, h_plus1;
   logic                  col_nz, pix_phase, ignore, accept, take;
   logic                  out_rdy, s3_rdy, s2_rdy, s1_go, s2_go, s3_go;
   logic [LINE_W-1:0]     line_rd, ram_rd_data;
   logic [PIXEL_BITS-1:0] top_pix, mid_pix;
   logic [KX_W-1:0]       krow_ext [3];
   logic signed [COEF_BITS-1:0] coef [3][3];
   logic [2:0]            row_ok, col_ok;

   // configuration port
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign geo_write = csr_we &&
                      ((csr_index == c3x3zp_pkg::CSR_IMAGE_WIDTH) ||
                       (csr_index == c3x3zp_pkg::CSR_IMAGE_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DIM_W'(1);
         height_ff    <= DIM_W'(1);
         kernel_ff[0] <= '0;
         kernel_ff[1] <= '0;
         kernel_ff[2] <= '0;
      end else if (csr_we) begin
         unique case (c3x3zp_pkg::c3x3zp_csr_type'(csr_index))
            c3x3zp_pkg::CSR_IMAGE_WIDTH:   width_ff     <= csr_data[DIM_W-1:0];
            c3x3zp_pkg::CSR_IMAGE_HEIGHT:  height_ff    <= csr_data[DIM_W-1:0];
            c3x3zp_pkg::CSR_KERNEL_TOP:    kernel_ff[0] <= csr_data[KROW_W-1:0];
            c3x3zp_pkg::CSR_KERNEL_MID:    kernel_ff[1] <= csr_data[KROW_W-1:0];
            c3x3zp_pkg::CSR_KERNEL_BOTTOM: kernel_ff[2] <= csr_data[KROW_W-1:0];
            default: ;
         endcase
      end
   end

   // effective geometry: zero counts as one, oversize clamps to the limit
   assign width_ext = EW'(width_ff);
   assign eff_w = (width_ff == '0) ? EW'(1) :
                  (width_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : width_ext;
   assign eff_h = (height_ff == '0) ? DIM_W'(1) :
                  (height_ff > DIM_W'(c3x3zp_pkg::HEIGHT_LIMIT)) ?
                  DIM_W'(c3x3zp_pkg::HEIGHT_LIMIT) : height_ff;
   assign h_plus1 = eff_h + DIM_W'(1);

   // pipeline handshake, back to front
   assign out_rdy   = !rsp_valid_ff || !rsp_stall;
   assign s3_rdy    = !s3_valid_ff || out_rdy;
   assign s2_rdy    = !s2_valid_ff || s3_rdy;
   assign s1_go     = s1_valid_ff && (!s1_tag_ff.emit || s2_rdy);
   assign s2_go     = s2_valid_ff && s3_rdy;
   assign s3_go     = s3_valid_ff && out_rdy;
   assign req_stall = s1_valid_ff && !s1_go;

   // item classification from the frame position
   assign col_ext   = EW'(col_ff);
   assign col_nz    = (col_ff != '0);
   assign pix_phase = (row_ff < eff_h);
   assign ignore    = pix_phase && (req_cmd == c3x3zp_pkg::CMD_FLUSH);
   assign accept    = req_valid && !req_stall;
   assign take      = accept && !ignore;
   assign pix_in    = pix_phase ? req_pixel : '0;

   // Center pixel is one row and one column behind the current item, or the
   // last column two rows up when the current item starts a row.
   always_comb begin
      tag_in.emit  = ((row_ff >= DIM_W'(2)) || ((row_ff == DIM_W'(1)) && col_nz)) &&
                     ((row_ff <= eff_h) || ((row_ff == h_plus1) && !col_nz));
      tag_in.eof   = (row_ff == h_plus1) && !col_nz;
      if (col_nz) begin
         tag_in.top_ok   = (row_ff >= DIM_W'(2));
         tag_in.bot_ok   = (row_ff < eff_h);
         tag_in.left_ok  = (col_ff >= ADDR_W'(2));
         tag_in.right_ok = 1'b1;
      end else begin
         tag_in.top_ok   = (row_ff >= DIM_W'(3));
         tag_in.bot_ok   = (row_ff <= eff_h);
         tag_in.left_ok  = (eff_w >= EW'(2));
         tag_in.right_ok = 1'b0;
      end
   end

   // frame position update
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (geo_write) begin
         col_in = '0;
         row_in = '0;
      end else if (take) begin
         if (tag_in.emit && tag_in.eof) begin
            col_in = '0;
            row_in = '0;
         end else if (col_ext + EW'(1) >= eff_w) begin
            col_in = '0;
            row_in = row_ff + DIM_W'(1);
         end else begin
            col_in = col_ff + ADDR_W'(1);
         end
      end
   end

   // line RAM: {upper, lower} per column
   c3x3zp_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_addr_ff),
      .wr_data ({mid_pix, s1_pix_ff}),
      .rd_en   (take),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // bypass when the entry read this cycle is written at the same edge
   assign line_rd     = fwd_hit_ff ? fwd_line_ff : ram_rd_data;
   assign top_pix     = line_rd[LINE_W-1:PIXEL_BITS];
   assign mid_pix     = line_rd[PIXEL_BITS-1:0];
   assign fwd_hit_in  = s1_go && (s1_addr_ff == col_ff);
   assign fwd_line_in = {mid_pix, s1_pix_ff};

   assign s1_valid_in = take || (s1_valid_ff && !s1_go);

   // window shift
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][1];
         win_in[k][1] = win_ff[k][2];
      end
      win_in[0][2] = top_pix;
      win_in[1][2] = mid_pix;
      win_in[2][2] = s1_pix_ff;
   end

   // kernel coefficients, column 0 in the low bits
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         krow_ext[k] = KX_W'(kernel_ff[k]);
         for (int j = 0; j < 3; j++) begin
            coef[k][j] = krow_ext[k][j*COEF_BITS +: COEF_BITS];
         end
      end
   end

   // nine masked products of the shifted window
   assign row_ok = {s1_tag_ff.bot_ok, 1'b1, s1_tag_ff.top_ok};
   assign col_ok = {s1_tag_ff.right_ok, 1'b1, s1_tag_ff.left_ok};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            if (row_ok[k] && col_ok[j]) begin
               prod_in[k][j] = $signed({1'b0, win_in[k][j]}) * coef[k][j];
            end else begin
               prod_in[k][j] = '0;
            end
         end
      end
   end

   assign s2_valid_in = (s1_go && s1_tag_ff.emit) || (s2_valid_ff && !s2_go);

   // row sums
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rowsum_in[k] = ROW_W'(prod_ff[k][0]) + ROW_W'(prod_ff[k][1]) +
                        ROW_W'(prod_ff[k][2]);
      end
   end

   assign s3_valid_in = s2_go || (s3_valid_ff && !s3_go);

   // final sum, wrapped to the result width
   assign acc_in = ACC_W'(rowsum_ff[0]) + ACC_W'(rowsum_ff[1]) + ACC_W'(rowsum_ff[2]);

   assign rsp_valid_in = s3_go || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            fwd_hit_ff <= fwd_hit_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         s1_tag_ff   <= tag_in;
         s1_addr_ff  <= col_ff;
         s1_pix_ff   <= pix_in;
         fwd_line_ff <= fwd_line_in;
      end
      if (s1_go) begin
         win_ff <= win_in;
      end
      if (s1_go && s1_tag_ff.emit) begin
         prod_ff   <= prod_in;
         s2_eof_ff <= s1_tag_ff.eof;
      end
      if (s2_go) begin
         rowsum_ff <= rowsum_in;
         s3_eof_ff <= s2_eof_ff;
      end
      if (s3_go) begin
         rsp_filtered_ff <= acc_in[FILT_W-1:0];
         rsp_eof_ff      <= s3_eof_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered     = rsp_filtered_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

endmodule

### design/c3x3zp_checker.sv
// Port-level assertions for the convolution filter core and their bind.
module c3x3zp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [c3x3zp_pkg::FILT_W-1:0] rsp_filtered,
   input logic                                 rsp_end_of_frame
);

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered) &&
                                 $stable(rsp_end_of_frame))
      else $error("stalled result changed or dropped");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input stalls only when a held result blocks the pipeline
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while output side can move");

   // stall is only meaningful with an offered item, and then a result must be waiting
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

endmodule

bind conv3x3_zero_pad_filter_core c3x3zp_checker u_c3x3zp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_filtered     (rsp_filtered),
   .rsp_end_of_frame (rsp_end_of_frame)
);

### bench/conv3x3_filter_checker.sv
`timescale 1ns / 1ps
// Watches the filter's channels, predicts each convolution sum and compares the result stream.
module conv3x3_filter_checker
   import c3x3zp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic                     req_cmd,
   input  logic [DEF_PIXEL_BITS-1:0] req_pixel,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [FILT_W-1:0] rsp_filtered,
   input  logic                     rsp_end_of_frame,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   output int                       pending,
   output int                       error_count
);

   localparam int MAX_W  = DEF_MAX_WIDTH;
   localparam int PIX_W  = DEF_PIXEL_BITS;
   localparam int COEF_W = DEF_COEF_BITS;

   typedef struct {
      logic signed [FILT_W-1:0] filtered;
      logic                     eof;
   } conv_sum_type;

   // predictor state
   logic [PIX_W-1:0]  upper_line [MAX_W];
   logic [PIX_W-1:0]  lower_line [MAX_W];
   logic [PIX_W-1:0]  win [9];
   logic [DIM_W-1:0]  width_reg, height_reg;
   logic [KROW_W-1:0] kernel_row [3];
   int unsigned       col_pos, row_pos, frame_items;
   conv_sum_type      expected_sums [$];

   // zero reads as one, anything past the limit reads as the limit
   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw,
                                             input int unsigned limit);
      if (raw == 0) return 1;
      if (raw > limit) return limit;
      return 32'(raw);
   endfunction

   function automatic logic signed [COEF_W-1:0] coef_of(input int k, input int j);
      return kernel_row[k][j*COEF_W +: COEF_W];
   endfunction

   function automatic void restart_frame();
      col_pos     = 0;
      row_pos     = 0;
      frame_items = 0;
   endfunction

   function automatic void clear_state();
      for (int i = 0; i < MAX_W; i++) begin
         upper_line[i] = '0;
         lower_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      for (int i = 0; i < 3; i++) kernel_row[i] = '0;
      width_reg  = DIM_W'(1);
      height_reg = DIM_W'(1);
      restart_frame();
      expected_sums.delete();
   endfunction

   function automatic void write_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] val);
      case (c3x3zp_csr_type'(idx))
         CSR_IMAGE_WIDTH: begin
            width_reg = val[DIM_W-1:0];
            restart_frame();
         end
         CSR_IMAGE_HEIGHT: begin
            height_reg = val[DIM_W-1:0];
            restart_frame();
         end
         CSR_KERNEL_TOP:    kernel_row[0] = val[KROW_W-1:0];
         CSR_KERNEL_MID:    kernel_row[1] = val[KROW_W-1:0];
         CSR_KERNEL_BOTTOM: kernel_row[2] = val[KROW_W-1:0];
         default: ;
      endcase
   endfunction

   // one accepted item: in-frame flushes drop; else shift, queue a sum when a center completes
   function automatic void advance_filter(input c3x3zp_cmd_type cmd,
                                          input logic [PIX_W-1:0] pix);
      int unsigned      w, h, n, t, c, r;
      int               rc, cc, nr, nc, k, j;
      logic [PIX_W-1:0] v, above, middle;
      longint           acc;
      conv_sum_type     sum;
      bit               last_sum;
      w = clamp_dim(width_reg, MAX_W);
      h = clamp_dim(height_reg, HEIGHT_LIMIT);
      n = w * h;
      t = frame_items;
      c = col_pos;
      r = row_pos;
      last_sum = 1'b0;
      // flush inside a frame is dropped
      if (t < n && cmd == CMD_FLUSH) return;
      // past the last pixel every item drains with a zero pixel
      v = (t < n) ? pix : '0;
      if (c >= w) c = 0;
      above  = upper_line[c];
      middle = lower_line[c];
      upper_line[c] = middle;
      lower_line[c] = v;
      for (k = 0; k < 3; k++) begin
         win[k*3]   = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = above;
      win[5] = middle;
      win[8] = v;
      // center lags the stream by one row and one pixel
      if (t >= w + 1 && t - w - 1 < n) begin
         if (c >= 1) begin
            rc = int'(r) - 1;
            cc = int'(c) - 1;
         end else begin
            rc = int'(r) - 2;
            cc = int'(w) - 1;
         end
         acc = 0;
         for (k = 0; k < 3; k++) begin
            for (j = 0; j < 3; j++) begin
               nr = rc + k - 1;
               nc = cc + j - 1;
               // taps outside the image count as zero
               if (nr >= 0 && nc >= 0 && nr < int'(h) && nc < int'(w))
                  acc += longint'(win[k*3+j]) * longint'(coef_of(k, j));
            end
         end
         sum.filtered = acc[FILT_W-1:0];
         sum.eof      = (t - w - 1 == n - 1);
         last_sum     = sum.eof;
         expected_sums.push_back(sum);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      col_pos     = c;
      row_pos     = r;
      frame_items = t + 1;
      if (last_sum) restart_frame();
   endfunction

   always @(posedge clock) begin : watch
      conv_sum_type want;
      if (reset) begin
         clear_state();
      end else begin
         // result transfer against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_sums.size() == 0) begin
               error_count++;
               $error("rsp_filtered: nothing expected, actual %0d", rsp_filtered);
            end else begin
               want = expected_sums.pop_front();
               if (rsp_filtered !== want.filtered) begin
                  error_count++;
                  $error("rsp_filtered: expected %0d, actual %0d",
                         want.filtered, rsp_filtered);
               end
               if (rsp_end_of_frame !== want.eof) begin
                  error_count++;
                  $error("rsp_end_of_frame: expected %0b, actual %0b",
                         want.eof, rsp_end_of_frame);
               end
            end
         end
         if (csr_valid && csr_ready) write_register(csr_index, csr_data);
         if (req_valid && !req_stall) advance_filter(c3x3zp_cmd_type'(req_cmd), req_pixel);
      end
      pending = expected_sums.size();
   end

endmodule

### bench/tb_conv3x3_zero_pad_filter_core.sv
`timescale 1ns / 1ps
// Top of the convolution filter bench: clock, reset, stimulus, receiver stalls and verdict.
module tb_conv3x3_zero_pad_filter_core;
   import c3x3zp_pkg::*;

   localparam int PIX_W         = DEF_PIXEL_BITS;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int SETTLE_CYCLES = 8;          // output stage depth plus margin
   localparam int LONG_HOLD     = 300;
   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam logic [PIX_W-1:0] PIX_FULL = '1;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid, req_stall, req_cmd;
   logic [PIX_W-1:0]         req_pixel;
   logic                     rsp_valid, rsp_stall;
   logic signed [FILT_W-1:0] rsp_filtered;
   logic                     rsp_end_of_frame;
   logic                     csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_data;

   int          pending, error_count;
   int unsigned cycle_count = 0;
   int unsigned cur_w, cur_h;      // geometry in force after clamping
   int unsigned random_items;
   bit          tx_quiet;          // sender offers items without gaps
   bit          long_hold_req;     // asks the receiver for one long stall

   always #2 clock = ~clock;

   conv3x3_zero_pad_filter_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_filtered     (rsp_filtered),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   conv3x3_filter_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_filtered     (rsp_filtered),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .pending          (pending),
      .error_count      (error_count)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw,
                                             input int unsigned limit);
      if (raw == 0) return 1;
      if (raw > limit) return limit;
      return 32'(raw);
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return PIX_FULL;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   function automatic logic [KROW_W-1:0] pick_kernel_row();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return {3{16'h8000}};
         2:       return {3{16'h7FFF}};
         3:       return {3{16'hFFFF}};
         4:       return {16'hF000, 16'h1000, 16'h0800};
         default: return KROW_W'({$urandom, $urandom});
      endcase
   endfunction

   // mostly small sizes, now and then zero or a few times the usual span
   function automatic logic [DIM_W-1:0] pick_dim(input int unsigned span);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return DIM_W'(1);
         9:       return DIM_W'($urandom_range(span, 3 * span));
         default: return DIM_W'($urandom_range(2, span));
      endcase
   endfunction

   // one input transfer after a random gap; valid stays up between back-to-back items
   task automatic send_item(input c3x3zp_cmd_type cmd, input logic [PIX_W-1:0] pix);
      int unsigned gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_pixel <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_pixels(input int unsigned count, input bit noisy);
      for (int unsigned p = 0; p < count; p++) begin
         // stray flush inside the frame
         if (noisy && $urandom_range(0, 15) == 0) send_item(CMD_FLUSH, PIX_W'($urandom));
         send_item(CMD_PIXEL, pick_pixel());
         random_items++;
      end
   endtask

   // width + 1 drain items; a pixel here acts as a flush
   task automatic send_drains();
      for (int unsigned d = 0; d <= cur_w; d++) begin
         if ($urandom_range(0, 3) == 0) send_item(CMD_PIXEL, pick_pixel());
         else send_item(CMD_FLUSH, PIX_W'($urandom));
         random_items++;
      end
   endtask

   // sender pauses until every result is back and the pipeline has emptied
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input c3x3zp_csr_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_geometry(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw);
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(w_raw));
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h_raw));
      cur_w = clamp_dim(w_raw, DEF_MAX_WIDTH);
      cur_h = clamp_dim(h_raw, HEIGHT_LIMIT);
   endtask

   task automatic set_kernel(input logic [KROW_W-1:0] k_top, input logic [KROW_W-1:0] k_mid,
                             input logic [KROW_W-1:0] k_bot);
      write_reg(CSR_KERNEL_TOP, CSR_DATA_W'(k_top));
      write_reg(CSR_KERNEL_MID, CSR_DATA_W'(k_mid));
      write_reg(CSR_KERNEL_BOTTOM, CSR_DATA_W'(k_bot));
   endtask

   // receiver: random stall after each transfer, quiet stretches, one long hold on request
   initial begin : result_side
      int unsigned hold, taken;
      bit          rx_quiet;
      rsp_stall = 1'b0;
      hold      = 0;
      taken     = 0;
      rx_quiet  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            taken++;
            if (taken % 40 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
            hold = rx_quiet ? 0 : $urandom_range(0, 17);
         end
         @(negedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_req = 1'b0;
            hold = 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int unsigned n, cut, choice, frame_no;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_cmd       = CMD_PIXEL;
      req_pixel     = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_IMAGE_WIDTH;
      csr_data      = '0;
      tx_quiet      = 1'b0;
      long_hold_req = 1'b0;
      cur_w         = 1;
      cur_h         = 1;
      random_items  = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // most negative kernel, full-scale 3x3 image with zero center, stray flush, mixed drains
      set_kernel({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
      set_geometry(DIM_W'(3), DIM_W'(3));
      for (int p = 0; p < 9; p++) begin
         if (p == 5) send_item(CMD_FLUSH, PIX_FULL);
         send_item(CMD_PIXEL, (p == 4) ? '0 : PIX_FULL);
      end
      send_item(CMD_PIXEL, 16'h1234);
      send_item(CMD_FLUSH, '0);
      send_item(CMD_FLUSH, PIX_FULL);
      send_item(CMD_PIXEL, 16'hEDCB);
      wait_idle();

      // largest kernel; zero geometry reads as 1x1; geometry rewrite mid-frame restarts
      set_kernel({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
      set_geometry('0, '0);
      send_item(CMD_PIXEL, PIX_FULL);
      wait_idle();
      set_geometry(DIM_W'(2), DIM_W'(1));
      send_item(CMD_PIXEL, '0);
      send_item(CMD_PIXEL, PIX_FULL);
      wait_idle();
      // kernel change before the frame's results come out
      write_reg(CSR_KERNEL_MID, CSR_DATA_W'({16'hF000, 16'h1000, 16'h0800}));
      send_drains();
      wait_idle();

      // oversize width clamps to the full line, then oversize height on a one-pixel column
      set_kernel(pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
      set_geometry('1, DIM_W'(2));
      send_pixels(cur_w * cur_h, 1'b0);
      send_drains();
      wait_idle();
      set_geometry('0, '1);
      send_pixels(cur_w * cur_h, 1'b1);
      send_drains();
      wait_idle();

      // random frames
      random_items = 0;
      frame_no     = 0;
      while (random_items < RANDOM_ITEMS) begin
         tx_quiet = ($urandom_range(0, 3) == 0);
         choice   = $urandom_range(0, 19);
         if (frame_no == 0 || choice == 0) begin
            // receiver holds off while the sender keeps offering, so the input backs up
            wait_idle();
            set_geometry(DIM_W'(10), DIM_W'(8));
            long_hold_req = 1'b1;
            tx_quiet      = 1'b1;
         end else if (choice < 8) begin
            wait_idle();
            set_geometry(pick_dim(12), pick_dim(6));
            if (choice < 5) set_kernel(pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
         end
         n      = cur_w * cur_h;
         // the first frame runs whole so the long hold always backs up the input
         choice = (frame_no == 0) ? 9 : $urandom_range(0, 9);
         if (choice == 0) begin
            // frame dropped part way, restarted by a geometry write
            cut = $urandom_range(0, n - 1);
            send_pixels(cut, 1'b1);
            wait_idle();
            set_geometry(pick_dim(12), pick_dim(6));
         end else if (choice == 1) begin
            // kernel rewritten in the middle of a frame
            cut = $urandom_range(0, n);
            send_pixels(cut, 1'b1);
            wait_idle();
            write_reg(c3x3zp_csr_type'($urandom_range(CSR_KERNEL_TOP, CSR_KERNEL_BOTTOM)),
                      CSR_DATA_W'(pick_kernel_row()));
            send_pixels(n - cut, 1'b1);
            send_drains();
         end else begin
            send_pixels(n, choice < 5);
            send_drains();
         end
         frame_no++;
      end

      wait_idle();
      if (error_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### files.f
design/c3x3zp_pkg.sv
design/c3x3zp_ram.sv
design/conv3x3_zero_pad_filter_core.sv
design/c3x3zp_checker.sv
bench/conv3x3_filter_checker.sv
bench/tb_conv3x3_zero_pad_filter_core.sv
